### design/ake_pkg.sv
// ----------------------------------------------------------------------------
// ake_pkg: shared types and constants for the aes-128 key expansion block
// transfer payloads, sequencer states, round control and gf(2^8) helper
// ----------------------------------------------------------------------------
package ake_pkg;

	localparam int unsigned WordCount = 44;
	localparam int unsigned WidxW     = 6;
	localparam logic [WidxW-1:0] LAST_WORD_IDX = 6'(WordCount - 1);
	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_REDUCE  = 8'h1b;

	// input function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_EXPAND = 1'b1;

	typedef struct packed {
		logic        func;
		logic [7:0]  table_index;
		logic [7:0]  table_value;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
	} in_item_t;

	typedef struct packed {
		logic [WidxW-1:0] word_index;
		logic [31:0]      round_word;
		logic             last_word;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// s-box lookup phases for the next round's substitution
	typedef enum logic [1:0] {
		LK_ADDR01,
		LK_ADDR23,
		LK_DATA23,
		LK_DONE
	} lk_phase_t;

	typedef struct packed {
		logic       load;
		logic       adv;
		logic [1:0] sel;
	} rnd_ctrl_t;

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		logic [7:0] d;
		d = {b[6:0], 1'b0};
		if (b[7]) begin
			d = d ^ GF_REDUCE;
		end
		return d;
	endfunction

endpackage

### design/ake_sbox_mem.sv
// ----------------------------------------------------------------------------
// ake_sbox_mem: 256 x 8 substitution table
// one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module ake_sbox_mem (
	input  logic       clk,
	input  logic       wr_en,
	input  logic [7:0] wr_addr,
	input  logic [7:0] wr_data,
	input  logic [7:0] rd_addr_a,
	input  logic [7:0] rd_addr_b,
	output logic [7:0] rd_data_a,
	output logic [7:0] rd_data_b
);

	logic [7:0] mem [256];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

### design/ake_round.sv
// ----------------------------------------------------------------------------
// ake_round: four-word key window and round update
// holds words 4r..4r+3 and the round constant, steps to the next round
// ----------------------------------------------------------------------------
module ake_round (
	input  logic              clk,
	input  logic              arst_n,
	input  ake_pkg::rnd_ctrl_t ctrl,
	input  logic [127:0]      key,
	input  logic [31:0]       sub_word,
	output logic [31:0]       sel_word,
	output logic [31:0]       last_col
);

	logic [31:0] win_q [4];
	logic [7:0]  rcon_q;
	logic [31:0] t;
	logic [31:0] nxt [4];

	always_comb begin
		t      = sub_word ^ {rcon_q, 24'h0};
		nxt[0] = win_q[0] ^ t;
		nxt[1] = win_q[1] ^ nxt[0];
		nxt[2] = win_q[2] ^ nxt[1];
		nxt[3] = win_q[3] ^ nxt[2];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			win_q[0] <= key[127:96];
			win_q[1] <= key[95:64];
			win_q[2] <= key[63:32];
			win_q[3] <= key[31:0];
		end else if (ctrl.adv) begin
			win_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcon_q <= ake_pkg::RCON_FIRST;
		end else if (ctrl.load) begin
			rcon_q <= ake_pkg::RCON_FIRST;
		end else if (ctrl.adv) begin
			rcon_q <= ake_pkg::gf_double(rcon_q);
		end
	end

	assign sel_word = win_q[ctrl.sel];
	assign last_col = win_q[3];

endmodule

### design/aes128_key_expansion.sv
// ----------------------------------------------------------------------------
// aes128_key_expansion: aes-128 key schedule with a loadable s-box
// a load transfer writes one table byte; an expand transfer
// emits the 44 round-key words, one per cycle when the output side never
// stalls; the 4-word window emits one word a cycle while the s-box's two
// read ports fetch the next round's four bytes; the first word passes
// through the run state and into the output register after the expand transfer
// reset clears control and the round constant; the table is not cleared
// ----------------------------------------------------------------------------
module aes128_key_expansion (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ake_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ake_pkg::out_item_t out_item
);

	ake_pkg::seq_state_t state_q, state_nxt;
	ake_pkg::lk_phase_t  phase_q, phase_nxt;
	ake_pkg::rnd_ctrl_t  rctrl;

	logic [ake_pkg::WidxW-1:0] wcnt_q;
	logic                      win_done_q;
	logic                      out_valid_q;
	ake_pkg::out_item_t        out_q;

	logic        in_fire;
	logic        load_fire;
	logic        exp_fire;
	logic        emit;
	logic        emit_pos3;
	logic        emit_last;
	logic        adv;
	logic        final_round;

	logic [7:0]  rd_addr_a, rd_addr_b;
	logic [7:0]  rd_data_a, rd_data_b;
	logic [7:0]  sub_q [4];
	logic [31:0] sel_word, last_col;

	// input transfers only while idle; loads write the table directly
	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (in_item.func == ake_pkg::FUNC_LOAD);
	assign exp_fire  = in_fire && (in_item.func == ake_pkg::FUNC_EXPAND);

	// emit a word into the output register when it is free or draining
	assign emit        = (state_q == ake_pkg::ST_RUN) && !win_done_q
	                     && (!out_valid_q || out_ready);
	assign emit_pos3   = emit && (wcnt_q[1:0] == 2'd3);
	assign emit_last   = emit && (wcnt_q == ake_pkg::LAST_WORD_IDX);
	assign final_round = (wcnt_q[ake_pkg::WidxW-1:2]
	                      == ake_pkg::LAST_WORD_IDX[ake_pkg::WidxW-1:2]);

	// step the window once its last word is out and the s-box bytes are in
	assign adv = (phase_q == ake_pkg::LK_DONE) && !final_round
	             && (win_done_q || emit_pos3);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ake_pkg::ST_IDLE: begin
				if (exp_fire) begin
					state_nxt = ake_pkg::ST_RUN;
				end
			end
			ake_pkg::ST_RUN: begin
				if (emit_last) begin
					state_nxt = ake_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ake_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		rctrl.load = 1'b0;
		rctrl.adv  = adv;
		rctrl.sel  = wcnt_q[1:0];
		unique case (state_q)
			ake_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				rctrl.load = exp_fire;
			end
			ake_pkg::ST_RUN: begin
				in_ready = 1'b0;
			end
			default: in_ready = 1'b0;
		endcase
	end

	// lookup sequence restarts on every new window
	always_comb begin
		phase_nxt = phase_q;
		if (exp_fire || adv) begin
			phase_nxt = ake_pkg::LK_ADDR01;
		end else begin
			unique case (phase_q)
				ake_pkg::LK_ADDR01: phase_nxt = ake_pkg::LK_ADDR23;
				ake_pkg::LK_ADDR23: phase_nxt = ake_pkg::LK_DATA23;
				ake_pkg::LK_DATA23: phase_nxt = ake_pkg::LK_DONE;
				ake_pkg::LK_DONE:   phase_nxt = ake_pkg::LK_DONE;
				default:            phase_nxt = ake_pkg::LK_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ake_pkg::ST_IDLE;
			wcnt_q     <= '0;
			win_done_q <= 1'b0;
			phase_q    <= ake_pkg::LK_DONE;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;

			// word counter
			if (exp_fire) begin
				wcnt_q <= '0;
			end else if (emit) begin
				wcnt_q <= wcnt_q + ake_pkg::WidxW'(1'b1);
			end

			// window exhausted, waiting for the round step
			if (exp_fire || adv) begin
				win_done_q <= 1'b0;
			end else if (emit_pos3) begin
				win_done_q <= 1'b1;
			end
		end
	end

	// rotated byte order of the window's last word
	always_comb begin
		if (phase_q == ake_pkg::LK_ADDR01) begin
			rd_addr_a = last_col[23:16];
			rd_addr_b = last_col[15:8];
		end else begin
			rd_addr_a = last_col[7:0];
			rd_addr_b = last_col[31:24];
		end
	end

	// capture each address pair's registered read data in the following phase
	always_ff @(posedge clk) begin
		if (phase_q == ake_pkg::LK_ADDR23) begin
			sub_q[0] <= rd_data_a;
			sub_q[1] <= rd_data_b;
		end
		if (phase_q == ake_pkg::LK_DATA23) begin
			sub_q[2] <= rd_data_a;
			sub_q[3] <= rd_data_b;
		end
	end

	ake_sbox_mem u_sbox (
		.clk       (clk),
		.wr_en     (load_fire),
		.wr_addr   (in_item.table_index),
		.wr_data   (in_item.table_value),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	ake_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rctrl),
		.key      ({in_item.key_hi, in_item.key_lo}),
		.sub_word ({sub_q[0], sub_q[1], sub_q[2], sub_q[3]}),
		.sel_word (sel_word),
		.last_col (last_col)
	);

	// output register, one word per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.word_index <= wcnt_q;
			out_q.round_word <= sel_word;
			out_q.last_word  <= (wcnt_q == ake_pkg::LAST_WORD_IDX);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

### bench/aes128_key_expansion_tb.sv
// ----------------------------------------------------------------------------
// aes128_key_expansion_tb: self-checking bench for the aes-128 key schedule
// fills the whole s-box through load transfers, then runs directed keys and
// a random mix of table rewrites and expansions; every round-key word is
// checked against a schedule computed in the bench from its own s-box copy,
// with random idle gaps and stalls on both channels
// ----------------------------------------------------------------------------
module aes128_key_expansion_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS   = 30;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = 20;
	localparam int unsigned MAX_PRINTS     = 40;

	// scoreboard: mirrors the s-box and queues the schedule words still owed
	class key_sched_scoreboard;
		bit [7:0]            sbox_copy [256];
		ake_pkg::out_item_t  pending_words [$];
		int unsigned         mismatches;
		int unsigned         words_checked;
		int unsigned         loads_seen;
		int unsigned         expands_seen;

		function new();
			foreach (sbox_copy[i]) sbox_copy[i] = 8'h00;
			mismatches    = 0;
			words_checked = 0;
			loads_seen    = 0;
			expands_seen  = 0;
		endfunction

		function logic [31:0] sub_rot(input logic [31:0] w);
			logic [31:0] r;
			r = {w[23:0], w[31:24]};
			return {sbox_copy[r[31:24]], sbox_copy[r[23:16]],
				sbox_copy[r[15:8]], sbox_copy[r[7:0]]};
		endfunction

		function void note_input(input ake_pkg::in_item_t it);
			logic [31:0]        w [ake_pkg::WordCount];
			logic [7:0]         rcon;
			logic [31:0]        t;
			ake_pkg::out_item_t exp_word;
			if (it.func == ake_pkg::FUNC_LOAD) begin
				sbox_copy[it.table_index] = it.table_value;
				loads_seen++;
				return;
			end
			expands_seen++;
			w[0] = it.key_hi[63:32];
			w[1] = it.key_hi[31:0];
			w[2] = it.key_lo[63:32];
			w[3] = it.key_lo[31:0];
			rcon = ake_pkg::RCON_FIRST;
			for (int i = 4; i < ake_pkg::WordCount; i++) begin
				t = w[i-1];
				if (i % 4 == 0) begin
					t = sub_rot(t) ^ {rcon, 24'h0};
					rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? ake_pkg::GF_REDUCE : 8'h00);
				end
				w[i] = w[i-4] ^ t;
			end
			for (int i = 0; i < ake_pkg::WordCount; i++) begin
				exp_word.word_index = ake_pkg::WidxW'(i);
				exp_word.round_word = w[i];
				exp_word.last_word  = (i == ake_pkg::WordCount - 1);
				pending_words.push_back(exp_word);
			end
		endfunction

		task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
			if (mismatches < MAX_PRINTS)
				$display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_word(input ake_pkg::out_item_t got);
			ake_pkg::out_item_t want;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", got.round_word, 32'h0);
				return;
			end
			want = pending_words.pop_front();
			words_checked++;
			if (got.word_index !== want.word_index)
				report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
			if (got.round_word !== want.round_word)
				report_mismatch("round_word", got.round_word, want.round_word);
			if (got.last_word !== want.last_word)
				report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	ake_pkg::in_item_t  in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ake_pkg::out_item_t out_item;

	key_sched_scoreboard sb = new();

	// handshake between the stimulus and the receiver for the long hold-off
	bit hold_req  = 1'b0;
	// stretches with no idling on either side
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	int unsigned quiet_cycles = 0;

	aes128_key_expansion uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// unused fields of each kind carry random noise
	function automatic ake_pkg::in_item_t load_item(input logic [7:0] idx,
		input logic [7:0] val);
		ake_pkg::in_item_t it;
		it.func        = ake_pkg::FUNC_LOAD;
		it.table_index = idx;
		it.table_value = val;
		it.key_hi      = rand64();
		it.key_lo      = rand64();
		return it;
	endfunction

	function automatic ake_pkg::in_item_t expand_item(input logic [63:0] hi,
		input logic [63:0] lo);
		ake_pkg::in_item_t it;
		it.func        = ake_pkg::FUNC_EXPAND;
		it.table_index = 8'($urandom());
		it.table_value = 8'($urandom());
		it.key_hi      = hi;
		it.key_lo      = lo;
		return it;
	endfunction

	// valid stays high across back-to-back transfers and drops only for a gap
	task automatic send_item(input ake_pkg::in_item_t it, input int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic send_random(input ake_pkg::in_item_t it);
		send_item(it, tx_steady ? 0 : pick_gap());
	endtask

	// sender goes quiet until every owed word has come out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_words.size() != 0) @(posedge clk);
	endtask

	// receiver: checks each accepted word, then picks next cycle's ready
	initial begin : rx_proc
		int unsigned stall_left;
		int unsigned r;
		int unsigned cyc;
		stall_left = 0;
		cyc        = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(out_item);
			cyc++;
			if (cyc % 200 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				// long hold-off so the block backs up into its input
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					stall_left = $urandom_range(0, 3);
					out_ready <= 1'b0;
				end else if (r < 14) begin
					stall_left = $urandom_range(15, 60);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles, %0d words owed",
					$realtime, quiet_cycles, sb.pending_words.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stim_proc
		int unsigned perm [256];
		int unsigned j;
		int unsigned tmp;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every s-box entry gets written before any expansion, in shuffled order
		foreach (perm[i]) perm[i] = i;
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		foreach (perm[i])
			send_random(load_item(8'(perm[i]), 8'($urandom())));

		// directed: table extremes, overwrite, key extremes and patterns
		send_item(load_item(8'h00, 8'hff), 0);
		send_item(load_item(8'h00, 8'h00), 0);
		send_item(load_item(8'hff, 8'hff), 0);
		send_item(expand_item(64'h0, 64'h0), 0);
		send_item(expand_item('1, '1), 1);
		send_item(expand_item('1, 64'h0), 0);
		send_item(expand_item(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa), 2);
		send_item(expand_item(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c), 0);
		// table rewrite right behind an expansion, then the same key again
		send_item(load_item(8'h3c, 8'h5a), 0);
		send_item(load_item(8'h16, 8'ha5), 0);
		send_item(expand_item(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c), 0);
		begin : unused_fields_ones
			ake_pkg::in_item_t it;
			it = load_item(8'h80, 8'h01);
			it.key_hi = '1;
			it.key_lo = '1;
			send_item(it, 0);
			it = expand_item(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000);
			it.table_index = 8'hff;
			it.table_value = 8'hff;
			send_item(it, 3);
		end
		send_item(expand_item(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210), 0);
		drain_outputs();

		// random mix of table rewrites and expansions
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 10 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			if (n == 5) begin
				// receiver holds off while expansions keep coming
				hold_req = 1'b1;
				repeat (6) send_item(expand_item(rand64(), rand64()), 0);
			end
			if (n == 20)
				drain_outputs();
			if ($urandom_range(0, 99) < 30)
				send_random(expand_item(rand64(), rand64()));
			else
				send_random(load_item(8'($urandom()), 8'($urandom())));
		end

		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_words.size() != 0)
			sb.report_mismatch("words never delivered", sb.pending_words.size(), 32'h0);

		$display("run covered %0d s-box loads and %0d key expansions, %0d round-key words checked",
			sb.loads_seen, sb.expands_seen, sb.words_checked);
		$display("stress included a %0d-cycle output hold-off and full drain pauses",
			HOLD_CYCLES);
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches found", sb.mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### files.f
design/ake_pkg.sv
design/ake_sbox_mem.sv
design/ake_round.sv
design/aes128_key_expansion.sv
bench/aes128_key_expansion_tb.sv
